### hdl/nnsa_pkg.sv
// Package for the nearest-neighbor scale address generator.
// Holds payload structs, register indexes, dimension limits and the clamp helper.
// Depends on nothing; every RTL file of the block imports it.
package nnsa_pkg;

  localparam int COORD_W         = 12;
  localparam int DIM_W           = 13;
  localparam int OFF_W           = 26;
  localparam int PROD_W          = 24;
  localparam int CFG_IDX_W       = 4;
  localparam int MAX_DIM         = 4096;
  localparam int BYTES_PER_PIXEL = 3;

  // Quotient bits resolved per divider stage, and the resulting stage count.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = COORD_W / DIV_STEPS;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = CFG_IDX_W'(3);

  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

  typedef struct packed {
    logic [COORD_W-1:0] target_col;
    logic [COORD_W-1:0] target_row;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] source_col;
    logic [COORD_W-1:0] source_row;
    logic [OFF_W-1:0]   source_offset;
    logic [OFF_W-1:0]   target_offset;
    logic               out_of_range;
  } out_t;

  // Values above the largest supported dimension are used saturated.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    clamp_dim = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

### hdl/nnsa_div.sv
// Pipelined restoring divider: 24-bit dividend by 13-bit divisor, 12-bit quotient.
// Resolves DIV_STEPS quotient bits per stage; uses nnsa_pkg for widths.
// The caller guarantees dividend < divisor * 2**COORD_W for meaningful results.
module nnsa_div (
  input  logic                          clk,
  input  logic [nnsa_pkg::DIV_STAGES-1:0] stg_en,
  input  logic [nnsa_pkg::PROD_W-1:0]   dividend,
  input  logic [nnsa_pkg::DIM_W-1:0]    divisor,
  output logic [nnsa_pkg::COORD_W-1:0]  quotient
);
  import nnsa_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] low;
    logic [COORD_W-1:0] quo;
  } div_t;

  // DIV_STEPS shift-compare-subtract steps of long division.
  function automatic div_t div_iter(input div_t a, input logic [DIM_W-1:0] d);
    div_t             r;
    logic [DIM_W-1:0] t;
    r = a;
    for (int j = 0; j < DIV_STEPS; j++) begin
      t     = {r.rem, r.low[COORD_W-1]};
      r.low = {r.low[COORD_W-2:0], 1'b0};
      if (t >= d) begin
        r.rem = COORD_W'(t - d);
        r.quo = {r.quo[COORD_W-2:0], 1'b1};
      end else begin
        r.rem = t[COORD_W-1:0];
        r.quo = {r.quo[COORD_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  div_t stg_r   [DIV_STAGES];
  div_t stg_nxt [DIV_STAGES];
  div_t first;

  // The upper half of the dividend is already below the divisor.
  assign first = '{rem: dividend[PROD_W-1:COORD_W],
                   low: dividend[COORD_W-1:0],
                   quo: '0};

  always_comb begin
    stg_nxt[0] = div_iter(first, divisor);
    for (int s = 1; s < DIV_STAGES; s++) begin
      stg_nxt[s] = div_iter(stg_r[s-1], divisor);
    end
  end

  // Each stage loads when the pipeline control lets it advance.
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (stg_en[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign quotient = stg_r[DIV_STAGES-1].quo;

endmodule

### hdl/nearest_neighbor_scale_address.sv
// Top level of the nearest-neighbor scale address generator.
// Depends on nnsa_pkg and on nnsa_div for the two pipelined divisions.
//
//   channel | ports                           | meaning
//   --------+---------------------------------+------------------------------------
//   in      | in_valid, in_ready, in_data     | destination coordinate item
//   out     | out_valid, out_ready, out_data  | source/destination address item
//   cfg     | cfg_valid, cfg_ready, cfg_index,| write of one dimension register
//           | cfg_data                        |
//
// One item enters per clock unless the pipeline is stalled; each accepted item
// passes through nine register stages, the divider resolving its twelve quotient
// bits at two bits per stage. Reset (synchronous, rst_n low) empties the pipeline
// and loads the default 640x480 dimensions. Each stage advances when it is empty
// or the stage after it advances, so a stalled output keeps its result while
// upstream bubbles still fill. Configuration writes are always taken.
module nearest_neighbor_scale_address (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nnsa_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nnsa_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]      cfg_data
);
  import nnsa_pkg::*;

  localparam int IDX_MUL = DIV_STAGES + 1;
  localparam int IDX_OUT = DIV_STAGES + 2;
  localparam int NSTG    = DIV_STAGES + 3;

  // Dimension registers, stored already saturated.
  logic [DIM_W-1:0] sw_r, sh_r, tw_r, th_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= RST_WIDTH;
      sh_r <= RST_HEIGHT;
      tw_r <= RST_WIDTH;
      th_r <= RST_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  sw_r <= clamp_dim(cfg_data);
        REG_SOURCE_HEIGHT: sh_r <= clamp_dim(cfg_data);
        REG_TARGET_WIDTH:  tw_r <= clamp_dim(cfg_data);
        REG_TARGET_HEIGHT: th_r <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and the advance chain from the output backward.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] stg_en;

  always_comb begin
    stg_en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[NSTG-1];

  // Stage 0: range check and the three scaling products.
  logic [PROD_W-1:0]  pcol_r, prow_r, dline_r;
  logic [COORD_W-1:0] x0_r;
  logic               oor0_r;

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      pcol_r  <= PROD_W'(in_data.target_col) * PROD_W'(sw_r);
      prow_r  <= PROD_W'(in_data.target_row) * PROD_W'(sh_r);
      dline_r <= PROD_W'(in_data.target_row) * PROD_W'(tw_r);
      x0_r    <= in_data.target_col;
      oor0_r  <= (DIM_W'(in_data.target_col) >= tw_r) ||
                 (DIM_W'(in_data.target_row) >= th_r);
    end
  end

  // Divider stages: source column and row quotients.
  logic [COORD_W-1:0] qcol, qrow;

  nnsa_div u_div_col (
    .clk      (clk),
    .stg_en   (stg_en[DIV_STAGES:1]),
    .dividend (pcol_r),
    .divisor  (tw_r),
    .quotient (qcol)
  );

  nnsa_div u_div_row (
    .clk      (clk),
    .stg_en   (stg_en[DIV_STAGES:1]),
    .dividend (prow_r),
    .divisor  (th_r),
    .quotient (qrow)
  );

  // Side data travelling alongside the divider; the destination offset is
  // finished on entry.
  logic [OFF_W-1:0] doff_q [DIV_STAGES];
  logic             oor_q  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      doff_q[0] <= OFF_W'((OFF_W'(dline_r) + OFF_W'(x0_r)) * OFF_W'(BYTES_PER_PIXEL));
      oor_q[0]  <= oor0_r;
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (stg_en[j+1]) begin
        doff_q[j] <= doff_q[j-1];
        oor_q[j]  <= oor_q[j-1];
      end
    end
  end

  // Source line product.
  logic [PROD_W-1:0]  sline_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [OFF_W-1:0]   doff_r;
  logic               oor_r;

  always_ff @(posedge clk) begin
    if (stg_en[IDX_MUL]) begin
      sline_r <= PROD_W'(qrow) * PROD_W'(sw_r);
      col_r   <= qcol;
      row_r   <= qrow;
      doff_r  <= doff_q[DIV_STAGES-1];
      oor_r   <= oor_q[DIV_STAGES-1];
    end
  end

  // Output register: source offset, and zeroed fields for out-of-range items.
  out_t res_nxt;
  out_t res_r;

  always_comb begin
    res_nxt.out_of_range = oor_r;
    if (oor_r) begin
      res_nxt.source_col    = '0;
      res_nxt.source_row    = '0;
      res_nxt.source_offset = '0;
      res_nxt.target_offset = '0;
    end else begin
      res_nxt.source_col    = col_r;
      res_nxt.source_row    = row_r;
      res_nxt.source_offset =
        OFF_W'((OFF_W'(sline_r) + OFF_W'(col_r)) * OFF_W'(BYTES_PER_PIXEL));
      res_nxt.target_offset = doff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[IDX_OUT]) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule
